// File: rtl/core/utf8d_pkg.sv
package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int CNT_W  = 3;   // 0..4 bytes in the work buffer
    localparam int BUF_D  = 4;   // three held bytes plus the new one

    // Lead byte classification
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'he0;
    localparam logic [7:0] LEAD2_VAL   = 8'hc0;
    localparam logic [7:0] LEAD3_MASK  = 8'hf0;
    localparam logic [7:0] LEAD3_VAL   = 8'he0;
    localparam logic [7:0] LEAD4_MASK  = 8'hf8;
    localparam logic [7:0] LEAD4_VAL   = 8'hf0;
    localparam logic [7:0] CONT_MASK   = 8'hc0;
    localparam logic [7:0] CONT_VAL    = 8'h80;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00fffd;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [CP_W-1:0]   cp_t;

    // Result of decoding the head of the work buffer
    typedef struct packed {
        logic stop;   // no result possible now (empty or waiting for bytes)
        cp_t  cp;
        logic bad;
        len_t len;
    } dec_t;

    // Sequencer steps
    typedef logic [1:0] step_t;
    localparam step_t STEP_WAIT   = 2'd0;
    localparam step_t STEP_DECODE = 2'd1;
    localparam step_t STEP_EMIT   = 2'd2;
    localparam step_t STEP_SPARE  = 2'd3;

    typedef enum logic {
        COND_ACCEPT,
        COND_STOP
    } cond_t;

    // One control word
    typedef struct packed {
        logic  take_in;     // open the input channel, load the byte on request
        logic  latch_res;   // capture the decoded result and consume its bytes
        logic  emit;        // push the held result to the output register
        logic  wait_out;    // step stalls while the output register is full
        cond_t cond;
        step_t jmp_true;
        step_t jmp_false;
    } ucode_t;

    localparam ucode_t UCODE [4] = '{
        // wait for a byte
        '{take_in: 1'b1, latch_res: 1'b0, emit: 1'b0, wait_out: 1'b0,
          cond: COND_ACCEPT, jmp_true: STEP_DECODE, jmp_false: STEP_WAIT},
        // first decode after the byte lands
        '{take_in: 1'b0, latch_res: 1'b1, emit: 1'b0, wait_out: 1'b0,
          cond: COND_STOP, jmp_true: STEP_WAIT, jmp_false: STEP_EMIT},
        // emit held result, decode the next one in the same step
        '{take_in: 1'b0, latch_res: 1'b1, emit: 1'b1, wait_out: 1'b1,
          cond: COND_STOP, jmp_true: STEP_WAIT, jmp_false: STEP_EMIT},
        // unused code
        '{take_in: 1'b0, latch_res: 1'b0, emit: 1'b0, wait_out: 1'b0,
          cond: COND_STOP, jmp_true: STEP_WAIT, jmp_false: STEP_WAIT}
    };

    // Control lines from the sequencer to the datapath
    typedef struct packed {
        logic ready;
        logic load_byte;
        logic latch_res;
        logic emit;
    } seq_ctl_t;

endpackage

// File: rtl/core/utf8d_if.sv
interface utf8d_byte_if
    import utf8d_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface utf8d_cp_if
    import utf8d_pkg::*;
;
    logic valid;
    logic ready;
    cp_t  code_point;
    logic is_replacement;
    len_t seq_length;
    logic last_of_run;
    logic text_done;

    modport source (output valid, output code_point, output is_replacement,
                    output seq_length, output last_of_run, output text_done,
                    input ready);
    modport sink   (input valid, input code_point, input is_replacement,
                    input seq_length, input last_of_run, input text_done,
                    output ready);
endinterface

// File: rtl/core/utf8d_decode.sv
module utf8d_decode
    import utf8d_pkg::*;
(
    input  byte_t buf_bytes [BUF_D],
    input  cnt_t  cnt,
    input  logic  eot,
    output dec_t  dec
);

    byte_t b0;
    len_t  need;
    logic  bad;
    logic  stop;

    assign b0 = buf_bytes[0];

    // Sequence length from the lead byte; zero marks a bad lead
    always_comb
    begin
        if (b0 < ASCII_LIMIT)
            need = 3'd1;
        else if ((b0 & LEAD2_MASK) == LEAD2_VAL)
            need = 3'd2;
        else if ((b0 & LEAD3_MASK) == LEAD3_VAL)
            need = 3'd3;
        else if ((b0 & LEAD4_MASK) == LEAD4_VAL)
            need = 3'd4;
        else
            need = 3'd0;
    end

    // Check the continuation bytes present, then completeness
    always_comb
    begin
        bad  = (need == 3'd0);
        stop = (cnt == '0);
        for (int i = 1; i < BUF_D; i++)
        begin
            if (3'(i) < need && 3'(i) < cnt &&
                (buf_bytes[i] & CONT_MASK) != CONT_VAL)
                bad = 1'b1;
        end
        if (!stop && !bad && cnt < need)
        begin
            if (eot)
                bad = 1'b1;
            else
                stop = 1'b1;
        end
    end

    // Assemble the code point
    always_comb
    begin
        dec.stop = stop;
        dec.bad  = bad;
        if (bad)
        begin
            dec.cp  = REPLACEMENT_CP;
            dec.len = 3'd1;
        end
        else
        begin
            dec.len = need;
            case (need)
                3'd2:    dec.cp = {10'b0, b0[4:0], buf_bytes[1][5:0]};
                3'd3:    dec.cp = {5'b0, b0[3:0], buf_bytes[1][5:0], buf_bytes[2][5:0]};
                3'd4:    dec.cp = {b0[2:0], buf_bytes[1][5:0], buf_bytes[2][5:0],
                                   buf_bytes[3][5:0]};
                default: dec.cp = {13'b0, b0};
            endcase
        end
    end

endmodule

// File: rtl/core/utf8d_seq.sv
module utf8d_seq
    import utf8d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  logic     stop,
    input  logic     out_busy,
    output seq_ctl_t ctl
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t uword;
    logic   go;
    logic   cond_val;

    assign uword    = UCODE[step_reg];
    assign go       = !(uword.wait_out && out_busy);
    assign cond_val = (uword.cond == COND_ACCEPT) ? accept : stop;

    // Control lines for this step
    assign ctl.ready     = uword.take_in;
    assign ctl.load_byte = uword.take_in && accept;
    assign ctl.latch_res = uword.latch_res && go && !stop;
    assign ctl.emit      = uword.emit && go;

    // Conditional jump
    always_comb
    begin
        if (!go)
            step_next = step_reg;
        else if (cond_val)
            step_next = uword.jmp_true;
        else
            step_next = uword.jmp_false;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_WAIT;
        else
            step_reg <= step_next;
    end

endmodule

// File: rtl/core/utf8_stream_decoder.sv
// Channel  Role  Payload                                            Request
// -------  ----  -------------------------------------------------  ---------------
// bytes    sink  data_byte[8], end_of_text                          valid & ready
// points   src   code_point[21], is_replacement, seq_length[3],     valid & ready
//                last_of_run, text_done
//
// A microcoded sequencer runs a three-step program per byte: a wait step takes
// the byte, a decode step decodes the buffer head, then the emit step runs once
// per code point; a byte yields from zero to four code points (R = 0..4).
// Reset clears the sequencer, the byte count and the output valid.
// A full output register holds the emit step; input is taken only in the wait step.
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    utf8d_byte_if.sink  bytes,
    utf8d_cp_if.source  points
);

    seq_ctl_t ctl;
    dec_t     dec;

    byte_t buf_reg [BUF_D];
    byte_t buf_next [BUF_D];
    cnt_t  cnt_reg;
    cnt_t  cnt_next;
    logic  eot_reg;

    // Result waiting for its last flag
    cp_t  res_cp_reg;
    logic res_bad_reg;
    len_t res_len_reg;

    logic out_valid_reg;
    cp_t  out_cp_reg;
    logic out_bad_reg;
    len_t out_len_reg;
    logic out_last_reg;
    logic out_done_reg;

    logic accept;
    logic out_busy;
    cnt_t shift_idx;

    assign accept   = bytes.valid && bytes.ready;
    assign out_busy = out_valid_reg && !points.ready;

    utf8d_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .stop     (dec.stop),
        .out_busy (out_busy),
        .ctl      (ctl)
    );

    utf8d_decode u_decode (
        .buf_bytes (buf_reg),
        .cnt       (cnt_reg),
        .eot       (eot_reg),
        .dec       (dec)
    );

    assign bytes.ready = ctl.ready;

    // Buffer update: append a byte, or drop the consumed head
    always_comb
    begin
        shift_idx = '0;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        if (ctl.load_byte)
        begin
            buf_next[cnt_reg[1:0]] = bytes.data_byte;
            cnt_next               = cnt_reg + 3'd1;
        end
        else if (ctl.latch_res)
        begin
            for (int i = 0; i < BUF_D; i++)
            begin
                shift_idx = 3'(i) + dec.len;
                if (shift_idx < 3'(BUF_D))
                    buf_next[i] = buf_reg[shift_idx[1:0]];
            end
            cnt_next = cnt_reg - dec.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        if (ctl.load_byte)
            eot_reg <= bytes.end_of_text;
        if (ctl.latch_res)
        begin
            res_cp_reg  <= dec.cp;
            res_bad_reg <= dec.bad;
            res_len_reg <= dec.len;
        end
    end

    // Output register; last flag is known once the next head has been decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.emit)
            out_valid_reg <= 1'b1;
        else if (points.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_cp_reg   <= res_cp_reg;
            out_bad_reg  <= res_bad_reg;
            out_len_reg  <= res_len_reg;
            out_last_reg <= dec.stop;
            out_done_reg <= dec.stop && eot_reg;
        end
    end

    assign points.valid          = out_valid_reg;
    assign points.code_point     = out_cp_reg;
    assign points.is_replacement = out_bad_reg;
    assign points.seq_length     = out_len_reg;
    assign points.last_of_run    = out_last_reg;
    assign points.text_done      = out_done_reg;

endmodule
